// ----- sv/rtbd_pkg.sv -----
// shared types and constants for the rotated text box decoder
`timescale 1ns / 1ps
package rtbd_pkg;
   localparam int CORDIC_STEPS = 16;
   localparam logic signed [19:0] PI_Q16 = 20'sd205887;
   localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
   localparam logic signed [19:0] CORDIC_GAIN_Q16 = 20'sd39797;
   localparam logic signed [22:0] DEG_PER_RAD_Q16 = 23'sd3754936;
   localparam logic [15:0] THRESHOLD_RESET = 16'd16384;

   // one accepted cell on its way from the front to the back
   typedef struct packed {
      logic [7:0]         cell_col;
      logic [7:0]         cell_row;
      logic [15:0]        score;
      logic signed [15:0] dist_top;
      logic signed [15:0] dist_right;
      logic signed [15:0] dist_bottom;
      logic signed [15:0] dist_left;
      logic signed [15:0] angle_rad;
   } cell_type;

   typedef struct packed {
      logic signed [19:0] center_x;
      logic signed [19:0] center_y;
      logic signed [16:0] box_width;
      logic signed [16:0] box_height;
      logic signed [16:0] angle_deg;
      logic [15:0]        confidence;
   } box_type;

   function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
      case (i)
         4'd0: atan_q16 = 20'sd51472;
         4'd1: atan_q16 = 20'sd30385;
         4'd2: atan_q16 = 20'sd16055;
         4'd3: atan_q16 = 20'sd8150;
         4'd4: atan_q16 = 20'sd4091;
         4'd5: atan_q16 = 20'sd2047;
         4'd6: atan_q16 = 20'sd1024;
         4'd7: atan_q16 = 20'sd512;
         4'd8: atan_q16 = 20'sd256;
         4'd9: atan_q16 = 20'sd128;
         4'd10: atan_q16 = 20'sd64;
         4'd11: atan_q16 = 20'sd32;
         4'd12: atan_q16 = 20'sd16;
         4'd13: atan_q16 = 20'sd8;
         4'd14: atan_q16 = 20'sd4;
         default: atan_q16 = 20'sd2;
      endcase
   endfunction
endpackage

// ----- sv/rtbd_front.sv -----
// front end: accepts cells, drops those under threshold or off the map
`timescale 1ns / 1ps
module rtbd_front import rtbd_pkg::*; #(
   parameter int MAP_SIDE_MAX = 256
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     csr_we,
   input  logic [15:0] csr_wdata,
   input  logic     in_valid,
   output logic     in_ready,
   input  cell_type in_cell,
   output logic     q_valid,
   input  logic     q_ready,
   output cell_type q_cell
);
   logic [15:0] thresh_ff, thresh_in;
   logic        keep;
   logic [1:0]  cnt_ff, cnt_in;
   cell_type    buf_ff [2];
   logic        rd_ff, rd_in, wr_ff, wr_in;
   logic        push, pop;

   // threshold register
   always_comb thresh_in = csr_we ? csr_wdata : thresh_ff;

   // classification
   assign keep = (in_cell.score >= thresh_ff)
      && ({24'd0, in_cell.cell_col} < 32'(MAP_SIDE_MAX))
      && ({24'd0, in_cell.cell_row} < 32'(MAP_SIDE_MAX));

   // two-entry queue toward the back end
   assign in_ready = (cnt_ff != 2'd2);
   assign push = in_valid && in_ready && keep;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign q_cell = buf_ff[rd_ff];
   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
      rd_in = rd_ff ^ pop;
      wr_in = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESHOLD_RESET;
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         thresh_ff <= thresh_in;
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
      if (push) buf_ff[wr_ff] <= in_cell;
   end
endmodule

// ----- sv/rtbd_back.sv -----
// back end: cordic pipeline and box geometry with stall-able stages
`timescale 1ns / 1ps
module rtbd_back import rtbd_pkg::*; #(
   parameter int CELL_STRIDE = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  cell_type in_cell,
   output logic     out_valid,
   input  logic     out_ready,
   output box_type  out_box
);
   localparam int NS = CORDIC_STEPS + 4;
   logic signed [21:0] x_ff [CORDIC_STEPS+1];
   logic signed [21:0] y_ff [CORDIC_STEPS+1];
   logic signed [20:0] z_ff [CORDIC_STEPS+1];
   logic               flip_ff [CORDIC_STEPS+1];
   cell_type           c_ff [NS];
   logic [NS:0]        v_ff;
   logic               adv;
   logic signed [21:0] s_ff, k_ff;
   logic signed [16:0] h_ff, w_ff;
   logic signed [39:0] cd1_ff, sd2_ff, sh_ff, cw_ff, sd1_ff, cd2_ff, sw_ff, ch_ff;
   logic signed [39:0] deg_ff;
   logic signed [44:0] ax_ff, ay_ff;
   logic signed [44:0] offx, offy, axr, ayr;
   logic signed [39:0] degr;
   box_type            box_ff;
   logic signed [20:0] z0;

   // whole pipeline moves when the output register is empty or being drained
   assign adv = !v_ff[NS] || out_ready;
   assign in_ready = adv;
   assign out_valid = v_ff[NS];
   assign out_box = box_ff;

   // angle range reduction
   always_comb z0 = 21'(in_cell.angle_rad) * 21'sd8;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[NS-1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_ff[0] <= in_cell;
         x_ff[0] <= 22'(CORDIC_GAIN_Q16);
         y_ff[0] <= '0;
         if (z0 > 21'(HALF_PI_Q16)) begin
            z_ff[0] <= z0 - 21'(PI_Q16); flip_ff[0] <= 1'b1;
         end else if (z0 < -21'(HALF_PI_Q16)) begin
            z_ff[0] <= z0 + 21'(PI_Q16); flip_ff[0] <= 1'b1;
         end else begin
            z_ff[0] <= z0; flip_ff[0] <= 1'b0;
         end
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            c_ff[i+1] <= c_ff[i];
            flip_ff[i+1] <= flip_ff[i];
            if (!z_ff[i][20]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - 21'(atan_q16(4'(i)));
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + 21'(atan_q16(4'(i)));
            end
         end
         // sign fix and sums
         c_ff[CORDIC_STEPS+1] <= c_ff[CORDIC_STEPS];
         s_ff <= flip_ff[CORDIC_STEPS] ? -y_ff[CORDIC_STEPS] : y_ff[CORDIC_STEPS];
         k_ff <= flip_ff[CORDIC_STEPS] ? -x_ff[CORDIC_STEPS] : x_ff[CORDIC_STEPS];
         h_ff <= 17'(c_ff[CORDIC_STEPS].dist_top) + 17'(c_ff[CORDIC_STEPS].dist_bottom);
         w_ff <= 17'(c_ff[CORDIC_STEPS].dist_right) + 17'(c_ff[CORDIC_STEPS].dist_left);
         // products
         c_ff[CORDIC_STEPS+2] <= c_ff[CORDIC_STEPS+1];
         cd1_ff <= 40'(k_ff) * 40'(c_ff[CORDIC_STEPS+1].dist_right);
         sd2_ff <= 40'(s_ff) * 40'(c_ff[CORDIC_STEPS+1].dist_bottom);
         sd1_ff <= 40'(s_ff) * 40'(c_ff[CORDIC_STEPS+1].dist_right);
         cd2_ff <= 40'(k_ff) * 40'(c_ff[CORDIC_STEPS+1].dist_bottom);
         sh_ff <= 40'(s_ff) * 40'(h_ff);
         cw_ff <= 40'(k_ff) * 40'(w_ff);
         sw_ff <= 40'(s_ff) * 40'(w_ff);
         ch_ff <= 40'(k_ff) * 40'(h_ff);
         // centre sums and degree product
         c_ff[CORDIC_STEPS+3] <= c_ff[CORDIC_STEPS+2];
         ax_ff <= 45'sd2 * (offx + 45'(cd1_ff) + 45'(sd2_ff)) - (45'(sh_ff) + 45'(cw_ff));
         ay_ff <= 45'sd2 * (offy - 45'(sd1_ff) + 45'(cd2_ff)) + (45'(sw_ff) - 45'(ch_ff));
         deg_ff <= -(40'(c_ff[CORDIC_STEPS+2].angle_rad) * 40'(DEG_PER_RAD_Q16));
         // round, saturate and register the result
         box_ff.center_x <= (axr > 45'sd524287) ? 20'sd524287 :
            (axr < -45'sd524288) ? -20'sd524288 : 20'(axr);
         box_ff.center_y <= (ayr > 45'sd524287) ? 20'sd524287 :
            (ayr < -45'sd524288) ? -20'sd524288 : 20'(ayr);
         box_ff.box_width <= 17'(c_ff[CORDIC_STEPS+3].dist_right)
            + 17'(c_ff[CORDIC_STEPS+3].dist_left);
         box_ff.box_height <= 17'(c_ff[CORDIC_STEPS+3].dist_top)
            + 17'(c_ff[CORDIC_STEPS+3].dist_bottom);
         box_ff.angle_deg <= (degr > 40'sd65535) ? 17'sd65535 :
            (degr < -40'sd65536) ? -17'sd65536 : 17'(degr);
         box_ff.confidence <= c_ff[CORDIC_STEPS+3].score;
      end
   end

   // cell offsets in q.22 and the rounding shifts
   always_comb begin
      offx = 45'({37'd0, c_ff[CORDIC_STEPS+2].cell_col}) * 45'(CELL_STRIDE) * 45'sd4194304;
      offy = 45'({37'd0, c_ff[CORDIC_STEPS+2].cell_row}) * 45'(CELL_STRIDE) * 45'sd4194304;
      axr = (ax_ff + 45'sd65536) >>> 17;
      ayr = (ay_ff + 45'sd65536) >>> 17;
      degr = (deg_ff + 40'sd1048576) >>> 21;
   end
endmodule

// ----- sv/rotated_text_box_decode_core.sv -----
// Rotated text box decoder top level: front classifier, queue, geometry back end.
// Path: front queue, cordic, sign fix, products, centre sums, output register.
// Throughput: one word per cycle if not stalled; 16-stage cordic fully pipelined.
// Words under threshold or off the map are dropped at the front with no result.
// Synchronous active-high reset clears valid state and loads threshold 16384.
`timescale 1ns / 1ps
module rotated_text_box_decode_core import rtbd_pkg::*; #(
   parameter int MAP_SIDE_MAX = 256,
   parameter int CELL_STRIDE = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // col, row, score, dist_top, dist_right, dist_bottom, dist_left, angle_rad
   input  logic [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // center_x, center_y, box_width, box_height, angle_deg, confidence, zero pad
   output logic [111:0] rsp_tdata
);
   cell_type req_cell, q_cell;
   box_type  box;
   logic     q_valid, q_ready;

   // unpack request word
   assign req_cell.cell_col    = req_tdata[7:0];
   assign req_cell.cell_row    = req_tdata[15:8];
   assign req_cell.score       = req_tdata[31:16];
   assign req_cell.dist_top    = req_tdata[47:32];
   assign req_cell.dist_right  = req_tdata[63:48];
   assign req_cell.dist_bottom = req_tdata[79:64];
   assign req_cell.dist_left   = req_tdata[95:80];
   assign req_cell.angle_rad   = req_tdata[111:96];

   rtbd_front #(.MAP_SIDE_MAX(MAP_SIDE_MAX)) u_front (
      .clock, .reset, .csr_we, .csr_wdata,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_cell(req_cell),
      .q_valid, .q_ready, .q_cell);

   rtbd_back #(.CELL_STRIDE(CELL_STRIDE)) u_back (
      .clock, .reset, .in_valid(q_valid), .in_ready(q_ready), .in_cell(q_cell),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_box(box));

   // pack response word
   assign rsp_tdata = {5'd0, box.confidence, box.angle_deg, box.box_height,
                       box.box_width, box.center_y, box.center_x};

`ifndef SYNTH
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word after reset");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");
   a_queue_pass: assert property (@(posedge clock) disable iff (reset)
      q_valid && !q_ready |=> q_valid)
      else $error("queue dropped a word");
`endif
endmodule
